@@ design/elo_rating_update_macros.svh @@
// assertion macros for the elo rating update block
// no dependencies; define ASSERT_OFF to compile the checks out
`ifndef ELO_RATING_UPDATE_MACROS_SVH
`define ELO_RATING_UPDATE_MACROS_SVH
`ifndef ASSERT_OFF
`define ELO_ASSERT_IMP(lbl, clk, rstn, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) \
		else $error("elo_rating_update: assertion failed");
`define ELO_ASSERT_NEXT(lbl, clk, rstn, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
		else $error("elo_rating_update: assertion failed");
`else
`define ELO_ASSERT_IMP(lbl, clk, rstn, ante, cons)
`define ELO_ASSERT_NEXT(lbl, clk, rstn, ante, cons)
`endif
`endif

@@ design/elo_pkg.sv @@
// shared types and constants of the elo rating update block
// no dependencies; used by the interfaces and all modules
`default_nettype none

package elo_pkg;

	localparam int PLAYER_W  = 10;
	localparam int OUTCOME_W = 17;
	localparam int RATING_W  = 32;
	localparam int PROB_W    = 17;
	localparam int CFG_W     = 32;
	localparam int CFG_IDX_W = 2;

	localparam logic [CFG_IDX_W-1:0] REG_K_FACTOR = 2'd0;
	localparam logic [CFG_IDX_W-1:0] REG_ALPHA    = 2'd1;

	localparam logic KIND_MATCH = 1'b0;
	localparam logic KIND_LOAD  = 1'b1;

	localparam logic [CFG_W-1:0] K_FACTOR_RST = 32'd2097152;
	localparam logic [CFG_W-1:0] ALPHA_RST    = 32'd96579;

	typedef struct packed {
		logic                       kind;
		logic [PLAYER_W-1:0]        player_a;
		logic [PLAYER_W-1:0]        player_b;
		logic [OUTCOME_W-1:0]       outcome;
		logic signed [RATING_W-1:0] load_value;
		logic                       batch_last;
	} req_t;

	typedef struct packed {
		logic [PROB_W-1:0]          win_prob;
		logic signed [RATING_W-1:0] rating_a_after;
		logic signed [RATING_W-1:0] rating_b_after;
		logic                       batch_end;
	} res_t;

	typedef struct packed {
		logic latch;
		logic clear;
		logic rd;
		logic logit;
		logic index;
		logic prob;
		logic gain;
		logic wr_load;
		logic wr_a;
		logic wr_b;
		logic out_load;
	} dp_cmd_t;

	typedef struct packed {
		logic load;
		logic clear_done;
	} dp_sts_t;

endpackage

`default_nettype wire

@@ design/elo_if.sv @@
// request, result and configuration channels of the elo rating update block
// depends on elo_pkg
`default_nettype none

interface elo_req_if;
	logic                                         valid;
	logic                                         ready;
	logic                                         kind;
	logic [elo_pkg::PLAYER_W-1:0]                 player_a;
	logic [elo_pkg::PLAYER_W-1:0]                 player_b;
	logic [elo_pkg::OUTCOME_W-1:0]                outcome;
	logic signed [elo_pkg::RATING_W-1:0]          load_value;
	logic                                         batch_last;

	modport source (output valid, kind, player_a, player_b, outcome, load_value, batch_last,
		input ready);
	modport sink (input valid, kind, player_a, player_b, outcome, load_value, batch_last,
		output ready);
endinterface

interface elo_rsp_if;
	logic                                valid;
	logic                                ready;
	logic [elo_pkg::PROB_W-1:0]          win_prob;
	logic signed [elo_pkg::RATING_W-1:0] rating_a_after;
	logic signed [elo_pkg::RATING_W-1:0] rating_b_after;
	logic                                batch_end;

	modport source (output valid, win_prob, rating_a_after, rating_b_after, batch_end,
		input ready);
	modport sink (input valid, win_prob, rating_a_after, rating_b_after, batch_end,
		output ready);
endinterface

interface elo_cfg_if;
	logic                          valid;
	logic                          ready;
	logic [elo_pkg::CFG_IDX_W-1:0] idx;
	logic [elo_pkg::CFG_W-1:0]     data;

	modport source (output valid, idx, data, input ready);
	modport sink (input valid, idx, data, output ready);
endinterface

`default_nettype wire

@@ design/elo_prob_rom.sv @@
// win probability rom, contents built at elaboration from a fixed-point sigmoid
// depends on elo_pkg
`default_nettype none

module elo_prob_rom #(
	parameter int SIGMOID_ENTRIES = 1024
) (
	input  wire logic                               clk,
	input  wire logic                               rd_en,
	input  wire logic [$clog2(SIGMOID_ENTRIES)-1:0] idx,
	output logic [elo_pkg::PROB_W-1:0]              data
);

	typedef longint unsigned u64_t;

	localparam u64_t Q31_ONE      = 64'd1 << 31;
	localparam u64_t SERIES_TERMS = 64'd20;
	localparam u64_t MAX_WHOLE    = 64'd16;
	localparam u64_t ENTRIES_U    = u64_t'(SIGMOID_ENTRIES);
	localparam u64_t HALF_ENTRIES = u64_t'(SIGMOID_ENTRIES / 2);

	function automatic u64_t q31_mul(input u64_t a, input u64_t b);
		return (a * b + (64'd1 << 30)) >> 31;
	endfunction

	// long division for the table contents, shift and subtract
	function automatic u64_t udiv(input u64_t a, input u64_t b);
		u64_t q;
		u64_t rem;
		q   = '0;
		rem = '0;
		for (int k = 63; k >= 0; k--) begin
			rem = {rem[62:0], a[k]};
			if (rem >= b) begin
				rem  = rem - b;
				q[k] = 1'b1;
			end
		end
		return q;
	endfunction

	// exp(-f), f in [0,1] as q1.31
	function automatic u64_t exp_neg_q31(input u64_t f);
		longint sum;
		u64_t   term;
		u64_t   n;
		sum  = longint'(Q31_ONE);
		term = Q31_ONE;
		for (n = 64'd1; n <= SERIES_TERMS; n++) begin
			term = udiv(q31_mul(term, f), n);
			if (n[0]) begin
				sum = sum - longint'(term);
			end else begin
				sum = sum + longint'(term);
			end
		end
		return u64_t'(sum);
	endfunction

	function automatic logic [elo_pkg::PROB_W-1:0] prob_entry(input int i);
		u64_t pos;
		u64_t half;
		u64_t n;
		u64_t m;
		u64_t r;
		u64_t f;
		u64_t t;
		u64_t e1;
		u64_t den;
		u64_t num;
		u64_t j;
		logic nonneg;
		pos    = u64_t'(32) * u64_t'(i);
		half   = u64_t'(16) * ENTRIES_U;
		nonneg = pos >= half;
		n      = nonneg ? pos - half : half - pos;
		m      = udiv(n, ENTRIES_U);
		r      = n - m * ENTRIES_U;
		f      = udiv((r << 31) + HALF_ENTRIES, ENTRIES_U);
		t      = exp_neg_q31(f);
		e1     = exp_neg_q31(Q31_ONE);
		for (j = 64'd0; j < MAX_WHOLE; j++) begin
			if (j < m) begin
				t = q31_mul(t, e1);
			end
		end
		den = Q31_ONE + t;
		num = nonneg ? (t << 16) : (Q31_ONE << 16);
		return elo_pkg::PROB_W'(udiv(num + (den >> 1), den));
	endfunction

	logic [elo_pkg::PROB_W-1:0] rom [SIGMOID_ENTRIES];

	for (genvar g = 0; g < SIGMOID_ENTRIES; g++) begin : g_rom
		localparam logic [elo_pkg::PROB_W-1:0] VAL = prob_entry(g);
		assign rom[g] = VAL;
	end

	always_ff @(posedge clk) begin
		if (rd_en) begin
			data <= rom[idx];
		end
	end

endmodule

`default_nettype wire

@@ design/elo_ctrl.sv @@
// sequencer of the elo rating update block: clear pass, match and load steps,
// result register handshake; depends on elo_pkg
`default_nettype none

module elo_ctrl (
	input  wire logic              clk,
	input  wire logic              arst_n,
	input  wire logic              req_valid,
	output logic                   req_ready,
	output logic                   rsp_valid,
	input  wire logic              rsp_ready,
	output elo_pkg::dp_cmd_t       cmd,
	input  wire elo_pkg::dp_sts_t  sts
);

	typedef enum logic [10:0] {
		ST_CLEAR = 11'b000_0000_0001,
		ST_IDLE  = 11'b000_0000_0010,
		ST_READ  = 11'b000_0000_0100,
		ST_LOAD  = 11'b000_0000_1000,
		ST_LOGIT = 11'b000_0001_0000,
		ST_INDEX = 11'b000_0010_0000,
		ST_PROB  = 11'b000_0100_0000,
		ST_GAIN  = 11'b000_1000_0000,
		ST_WR_A  = 11'b001_0000_0000,
		ST_WR_B  = 11'b010_0000_0000,
		ST_DONE  = 11'b100_0000_0000
	} state_t;

	state_t state_q;
	state_t state_nxt;
	logic   rsp_valid_q;

	always_comb begin
		state_nxt = state_q;
		cmd       = '0;
		case (state_q)
			ST_CLEAR: begin
				cmd.clear = 1'b1;
				if (sts.clear_done) begin
					state_nxt = ST_IDLE;
				end
			end
			ST_IDLE: begin
				if (req_valid) begin
					cmd.latch = 1'b1;
					state_nxt = ST_READ;
				end
			end
			ST_READ: begin
				cmd.rd    = 1'b1;
				state_nxt = sts.load ? ST_LOAD : ST_LOGIT;
			end
			ST_LOAD: begin
				cmd.wr_load = 1'b1;
				state_nxt   = ST_DONE;
			end
			ST_LOGIT: begin
				cmd.logit = 1'b1;
				state_nxt = ST_INDEX;
			end
			ST_INDEX: begin
				cmd.index = 1'b1;
				state_nxt = ST_PROB;
			end
			ST_PROB: begin
				cmd.prob  = 1'b1;
				state_nxt = ST_GAIN;
			end
			ST_GAIN: begin
				cmd.gain  = 1'b1;
				state_nxt = ST_WR_A;
			end
			ST_WR_A: begin
				cmd.wr_a  = 1'b1;
				state_nxt = ST_WR_B;
			end
			ST_WR_B: begin
				cmd.wr_b  = 1'b1;
				state_nxt = ST_DONE;
			end
			ST_DONE: begin
				if (!rsp_valid_q || rsp_ready) begin
					cmd.out_load = 1'b1;
					state_nxt    = ST_IDLE;
				end
			end
			default: begin
				state_nxt = ST_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_CLEAR;
			rsp_valid_q <= 1'b0;
		end else begin
			state_q <= state_nxt;
			if (cmd.out_load) begin
				rsp_valid_q <= 1'b1;
			end else if (rsp_ready) begin
				rsp_valid_q <= 1'b0;
			end
		end
	end

	assign req_ready = (state_q == ST_IDLE);
	assign rsp_valid = rsp_valid_q;

endmodule

`default_nettype wire

@@ design/elo_dp.sv @@
// datapath of the elo rating update block: rating memory, config registers,
// logit and gain multipliers, saturation; depends on elo_pkg and elo_prob_rom
`default_nettype none

module elo_dp #(
	parameter int PLAYERS         = 1024,
	parameter int SIGMOID_ENTRIES = 1024
) (
	input  wire logic                            clk,
	input  wire logic                            arst_n,
	input  wire elo_pkg::req_t                   req_pl,
	input  wire logic                            cfg_wr,
	input  wire logic [elo_pkg::CFG_IDX_W-1:0]   cfg_idx,
	input  wire logic [elo_pkg::CFG_W-1:0]       cfg_data,
	input  wire elo_pkg::dp_cmd_t                cmd,
	output elo_pkg::dp_sts_t                     sts,
	output elo_pkg::res_t                        res
);

	localparam int AW         = $clog2(PLAYERS);
	localparam int IXW        = $clog2(SIGMOID_ENTRIES);
	localparam int EW         = $clog2(SIGMOID_ENTRIES + 1);
	localparam int LOGIT_FRAC = 44;
	localparam int RECIP_SH   = 2 * elo_pkg::PLAYER_W;
	localparam longint RECIP  = (longint'(1) << RECIP_SH) / PLAYERS + 1;
	localparam int PW         = elo_pkg::PLAYER_W;
	localparam int RW         = elo_pkg::RATING_W;

	// index modulo players by reciprocal multiply
	function automatic logic [AW-1:0] player_idx(input logic [PW-1:0] x);
		logic [PW+RECIP_SH-1:0] prod;
		logic [PW-1:0]          q;
		logic [2*PW-1:0]        qp;
		logic [PW-1:0]          r;
		prod = (PW + RECIP_SH)'(x) * (PW + RECIP_SH)'(RECIP);
		q    = prod[RECIP_SH +: PW];
		qp   = (2 * PW)'(q) * (2 * PW)'(PLAYERS);
		r    = x - qp[PW-1:0];
		if (PLAYERS >= (1 << PW)) begin
			return AW'(x);
		end else begin
			return AW'(r);
		end
	endfunction

	function automatic logic signed [RW-1:0] sat32(input logic signed [35:0] v);
		logic ovf;
		ovf = (v[35:31] != {5{v[35]}});
		if (ovf) begin
			return v[35] ? 32'sh8000_0000 : 32'sh7fff_ffff;
		end else begin
			return v[RW-1:0];
		end
	endfunction

	logic [elo_pkg::CFG_W-1:0] k_q;
	logic [elo_pkg::CFG_W-1:0] alpha_q;
	logic [AW-1:0]             clr_cnt_q;
	logic                      clr_done;

	logic                          kind_q;
	logic [AW-1:0]                 a_idx_q;
	logic [AW-1:0]                 b_idx_q;
	logic                          same_q;
	logic [elo_pkg::OUTCOME_W-1:0] outcome_q;
	logic signed [RW-1:0]          load_q;
	logic                          last_q;

	logic signed [RW-1:0] mem [PLAYERS];
	logic signed [RW-1:0] ra_q;
	logic signed [RW-1:0] rb_q;

	logic signed [RW:0]   diff;
	logic [RW-1:0]        mag;
	logic                 neg_q;
	logic [63:0]          lprod_q;

	logic                 logit_sat;
	logic [LOGIT_FRAC:0]  shifted;
	logic [LOGIT_FRAC+EW:0] iprod;
	logic [IXW-1:0]       idx_nxt;
	logic [IXW-1:0]       idx_q;
	logic [elo_pkg::PROB_W-1:0] prob;

	logic signed [17:0]   gdiff;
	logic signed [50:0]   gprod_q;
	logic signed [34:0]   upd;
	logic signed [35:0]   sum_a;
	logic signed [35:0]   sum_b;
	logic signed [RW-1:0] sat_a;
	logic signed [RW-1:0] sat_b;
	logic signed [RW-1:0] new_a_q;
	logic signed [RW-1:0] new_b_q;

	logic                 wr_en;
	logic [AW-1:0]        wr_addr;
	logic signed [RW-1:0] wr_data;

	elo_pkg::res_t        res_q;

	// config registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			k_q     <= elo_pkg::K_FACTOR_RST;
			alpha_q <= elo_pkg::ALPHA_RST;
		end else if (cfg_wr) begin
			case (cfg_idx)
				elo_pkg::REG_K_FACTOR: k_q     <= cfg_data;
				elo_pkg::REG_ALPHA:    alpha_q <= cfg_data;
				default: ;
			endcase
		end
	end

	// clear pass counter
	assign clr_done = (clr_cnt_q == AW'(PLAYERS - 1));

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			clr_cnt_q <= '0;
		end else if (cmd.clear && !clr_done) begin
			clr_cnt_q <= clr_cnt_q + AW'(1);
		end
	end

	// request capture
	always_ff @(posedge clk) begin
		if (cmd.latch) begin
			kind_q    <= req_pl.kind;
			a_idx_q   <= player_idx(req_pl.player_a);
			b_idx_q   <= player_idx(req_pl.player_b);
			same_q    <= (player_idx(req_pl.player_a) == player_idx(req_pl.player_b));
			outcome_q <= req_pl.outcome;
			load_q    <= req_pl.load_value;
			last_q    <= req_pl.batch_last;
		end
	end

	// rating memory, one write port and two registered read ports
	always_comb begin
		wr_en   = 1'b0;
		wr_addr = clr_cnt_q;
		wr_data = '0;
		if (cmd.clear) begin
			wr_en = 1'b1;
		end else if (cmd.wr_load) begin
			wr_en   = 1'b1;
			wr_addr = a_idx_q;
			wr_data = load_q;
		end else if (cmd.wr_a) begin
			wr_en   = !same_q;
			wr_addr = a_idx_q;
			wr_data = sat_a;
		end else if (cmd.wr_b) begin
			wr_en   = !same_q;
			wr_addr = b_idx_q;
			wr_data = sat_b;
		end
	end

	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem[wr_addr] <= wr_data;
		end
		if (cmd.rd) begin
			ra_q <= mem[a_idx_q];
			rb_q <= mem[b_idx_q];
		end
	end

	// logit = alpha * (rb - ra), magnitude form
	assign diff = (RW + 1)'(rb_q) - (RW + 1)'(ra_q);
	assign mag  = diff[RW] ? RW'(-diff) : RW'(diff);

	always_ff @(posedge clk) begin
		if (cmd.logit) begin
			neg_q   <= diff[RW];
			lprod_q <= 64'(mag) * 64'(alpha_q);
		end
	end

	// table index from clamped logit
	assign logit_sat = |lprod_q[63:LOGIT_FRAC];
	assign shifted   = neg_q ? ({1'b1, {LOGIT_FRAC{1'b0}}} - {1'b0, lprod_q[LOGIT_FRAC-1:0]})
	                         : ({1'b1, {LOGIT_FRAC{1'b0}}} + {1'b0, lprod_q[LOGIT_FRAC-1:0]});
	assign iprod     = (LOGIT_FRAC + EW + 1)'(shifted) * (LOGIT_FRAC + EW + 1)'(SIGMOID_ENTRIES);

	always_comb begin
		if (logit_sat) begin
			idx_nxt = neg_q ? '0 : IXW'(SIGMOID_ENTRIES - 1);
		end else begin
			idx_nxt = iprod[LOGIT_FRAC+1 +: IXW];
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.index) begin
			idx_q <= idx_nxt;
		end
	end

	elo_prob_rom #(
		.SIGMOID_ENTRIES(SIGMOID_ENTRIES)
	) u_rom (
		.clk  (clk),
		.rd_en(cmd.prob),
		.idx  (idx_q),
		.data (prob)
	);

	// update = k * (outcome - prob) >>> 16
	assign gdiff = $signed({1'b0, outcome_q}) - $signed({1'b0, prob});

	always_ff @(posedge clk) begin
		if (cmd.gain) begin
			gprod_q <= 51'($signed({1'b0, k_q})) * 51'(gdiff);
		end
	end

	assign upd   = $signed(gprod_q[50:16]);
	assign sum_a = 36'(ra_q) + 36'(upd);
	assign sum_b = 36'(rb_q) - 36'(upd);
	assign sat_a = sat32(sum_a);
	assign sat_b = sat32(sum_b);

	always_ff @(posedge clk) begin
		if (cmd.wr_a) begin
			new_a_q <= sat_a;
		end
		if (cmd.wr_b) begin
			new_b_q <= sat_b;
		end
	end

	// result register
	always_ff @(posedge clk) begin
		if (cmd.out_load) begin
			res_q.batch_end <= last_q;
			if (kind_q == elo_pkg::KIND_LOAD) begin
				res_q.win_prob       <= '0;
				res_q.rating_a_after <= load_q;
				res_q.rating_b_after <= '0;
			end else begin
				res_q.win_prob       <= prob;
				res_q.rating_a_after <= same_q ? ra_q : new_a_q;
				res_q.rating_b_after <= same_q ? rb_q : new_b_q;
			end
		end
	end

	assign res             = res_q;
	assign sts.load        = (kind_q == elo_pkg::KIND_LOAD);
	assign sts.clear_done  = clr_done;

endmodule

`default_nettype wire

@@ design/elo_rating_update.sv @@
// top level of the elo rating update block: sequencer, datapath, checks
// depends on elo_pkg, elo_if, elo_ctrl, elo_dp and elo_rating_update_macros.svh
//
// usage:
// - req carries one request per valid/ready handshake: a match (kind 0) reads the
//   ratings of players a and b, looks up the win probability of a and applies the
//   update to both; a load (kind 1) writes the rating of player a
// - rsp returns exactly one result per request, in order
// - cfg writes k_factor (index 0) or alpha (index 1); always ready, other indexes
//   are ignored; write only while no request is in flight
// - a match passes through the read, logit multiply, index, rom read, gain multiply,
//   two writes on the single memory write port and the result register; a load
//   through the read, the load write and the result register; the next request is
//   taken only once the result is registered, so the block works on one request at
//   a time
// - the result sits in an output register; a new request is accepted while it
//   waits, and a stalled rsp holds the next result in its last step
// - after reset the rating memory is cleared, one entry a cycle: req.ready stays
//   low until the last entry is cleared; config writes are taken during that pass
`default_nettype none
`include "elo_rating_update_macros.svh"

module elo_rating_update #(
	parameter int PLAYERS         = 1024,
	parameter int SIGMOID_ENTRIES = 1024
) (
	input wire logic   clk,
	input wire logic   arst_n,
	elo_req_if.sink    req,
	elo_rsp_if.source  rsp,
	elo_cfg_if.sink    cfg
);

	elo_pkg::dp_cmd_t cmd;
	elo_pkg::dp_sts_t sts;
	elo_pkg::req_t    req_pl;
	elo_pkg::res_t    res;
	logic [3:0]       mem_wr_cmds;

	assign req_pl.kind       = req.kind;
	assign req_pl.player_a   = req.player_a;
	assign req_pl.player_b   = req.player_b;
	assign req_pl.outcome    = req.outcome;
	assign req_pl.load_value = req.load_value;
	assign req_pl.batch_last = req.batch_last;

	assign cfg.ready = 1'b1;

	elo_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.req_valid(req.valid),
		.req_ready(req.ready),
		.rsp_valid(rsp.valid),
		.rsp_ready(rsp.ready),
		.cmd      (cmd),
		.sts      (sts)
	);

	elo_dp #(
		.PLAYERS        (PLAYERS),
		.SIGMOID_ENTRIES(SIGMOID_ENTRIES)
	) u_dp (
		.clk     (clk),
		.arst_n  (arst_n),
		.req_pl  (req_pl),
		.cfg_wr  (cfg.valid),
		.cfg_idx (cfg.idx),
		.cfg_data(cfg.data),
		.cmd     (cmd),
		.sts     (sts),
		.res     (res)
	);

	assign rsp.win_prob       = res.win_prob;
	assign rsp.rating_a_after = res.rating_a_after;
	assign rsp.rating_b_after = res.rating_b_after;
	assign rsp.batch_end      = res.batch_end;

	assign mem_wr_cmds = {cmd.clear, cmd.wr_load, cmd.wr_a, cmd.wr_b};

	`ELO_ASSERT_IMP(a_ready_after_clear, clk, arst_n, req.ready, sts.clear_done)
	`ELO_ASSERT_IMP(a_no_write_when_ready, clk, arst_n, |mem_wr_cmds, !req.ready)
	`ELO_ASSERT_IMP(a_one_write_source, clk, arst_n, 1'b1, $onehot0(mem_wr_cmds))
	`ELO_ASSERT_NEXT(a_one_request_in_work, clk, arst_n, req.valid && req.ready, !req.ready)

endmodule

`default_nettype wire

@@ tb/tb.sv @@
// self-checking bench for elo_rating_update: directed rows, then random matches and loads
// over several k_factor/alpha settings; checked against typed rows or an in-bench rating predictor
// depends on elo_pkg, elo_if and the elo_rating_update rtl
`default_nettype none

module tb;
	timeunit 1ns;
	timeprecision 1ps;

	typedef longint unsigned u64_t;

	localparam int LUT_N       = 1024;
	localparam int PLAYERS     = 1024;
	localparam int IDLE_LIMIT  = 6000;
	localparam int HOLD_CYCLES = 400;
	localparam int PHASE_ITEMS = 222;

	localparam logic [elo_pkg::CFG_IDX_W-1:0] REG_SPARE_2 = 2'd2;
	localparam logic [elo_pkg::CFG_IDX_W-1:0] REG_SPARE_3 = 2'd3;

	localparam u64_t   Q31        = 64'd1 << 31;
	localparam u64_t   LOGIT_SAT  = 64'd1 << 44;
	localparam longint RATING_MAX = 64'sh7fff_ffff;
	localparam longint RATING_MIN = -64'sh8000_0000;

	typedef struct {
		elo_pkg::req_t item;
		bit            typed;
		elo_pkg::res_t want;
	} dir_row_t;

	logic clk;
	logic arst_n;

	elo_req_if req ();
	elo_rsp_if rsp ();
	elo_cfg_if cfg ();

	elo_rating_update dut (
		.clk    (clk),
		.arst_n (arst_n),
		.req    (req),
		.rsp    (rsp),
		.cfg    (cfg)
	);

	int unsigned               sigmoid_lut [LUT_N];
	int                        rating_mem [PLAYERS];
	logic [elo_pkg::CFG_W-1:0] k_gain;
	logic [elo_pkg::CFG_W-1:0] logit_gain;
	elo_pkg::res_t             pending_results [$];
	int                        errors = 0;
	int                        idle_cycles = 0;
	bit                        calm = 1'b0;
	bit                        hold_off = 1'b0;

	function automatic u64_t q31_prod(u64_t a, u64_t b);
		return (a * b + (64'd1 << 30)) >> 31;
	endfunction

	// exp(-f), f in [0,1] as q1.31, by truncated taylor series
	function automatic u64_t exp_neg(u64_t f);
		longint sum;
		u64_t   term;
		sum = longint'(Q31);
		term = Q31;
		for (int n = 1; n <= 20; n++) begin
			term = q31_prod(term, f) / u64_t'(n);
			if (n % 2 == 1) begin
				sum -= longint'(term);
			end else begin
				sum += longint'(term);
			end
		end
		return $unsigned(sum);
	endfunction

	function automatic void build_lut();
		u64_t e1, half, pos, dist_n, m, r, f, t, den, num;
		e1 = exp_neg(Q31);
		half = u64_t'(16 * LUT_N);
		for (int i = 0; i < LUT_N; i++) begin
			pos = u64_t'(32 * i);
			dist_n = (pos >= half) ? pos - half : half - pos;
			m = dist_n / u64_t'(LUT_N);
			r = dist_n % u64_t'(LUT_N);
			f = ((r << 31) + u64_t'(LUT_N / 2)) / u64_t'(LUT_N);
			t = exp_neg(f);
			repeat (m) t = q31_prod(t, e1);
			den = Q31 + t;
			num = (pos >= half) ? t * 64'd65536 : Q31 * 64'd65536;
			sigmoid_lut[i] = 32'((num + den / 64'd2) / den);
		end
	endfunction

	function automatic int unsigned lut_prob(longint diff);
		u64_t mag, prod, idx;
		mag = (diff < 0) ? -diff : diff;
		prod = mag * {32'd0, logit_gain};
		if (diff >= 0) begin
			idx = (prod >= LOGIT_SAT) ? u64_t'(LUT_N - 1)
			                          : (((prod + LOGIT_SAT) * u64_t'(LUT_N)) >> 45);
		end else begin
			idx = (prod >= LOGIT_SAT) ? 64'd0 : (((LOGIT_SAT - prod) * u64_t'(LUT_N)) >> 45);
		end
		if (idx >= u64_t'(LUT_N)) begin
			idx = u64_t'(LUT_N - 1);
		end
		return sigmoid_lut[idx];
	endfunction

	function automatic int sat32(longint v);
		if (v > RATING_MAX) begin
			v = RATING_MAX;
		end else if (v < RATING_MIN) begin
			v = RATING_MIN;
		end
		return v[31:0];
	endfunction

	function automatic elo_pkg::res_t elo_predict(elo_pkg::req_t r);
		elo_pkg::res_t o;
		longint        ra, rb, gain_prod, upd;
		int unsigned   p;
		o.batch_end = r.batch_last;
		if (r.kind == elo_pkg::KIND_LOAD) begin
			rating_mem[r.player_a] = r.load_value;
			o.win_prob = '0;
			o.rating_a_after = r.load_value;
			o.rating_b_after = '0;
			return o;
		end
		ra = rating_mem[r.player_a];
		rb = rating_mem[r.player_b];
		p = lut_prob(rb - ra);
		o.win_prob = p[elo_pkg::PROB_W-1:0];
		if (r.player_a != r.player_b) begin
			gain_prod = longint'(k_gain) * (longint'(r.outcome) - longint'(p));
			upd = gain_prod >>> 16;
			rating_mem[r.player_a] = sat32(ra + upd);
			rating_mem[r.player_b] = sat32(rb - upd);
		end
		o.rating_a_after = rating_mem[r.player_a];
		o.rating_b_after = rating_mem[r.player_b];
		return o;
	endfunction

	function automatic void check_field(string name, logic [31:0] want, logic [31:0] got);
		if (want !== got) begin
			$display("%0t: %s expected %0h got %0h", $time, name, want, got);
			errors++;
		end
	endfunction

	function automatic dir_row_t mk_row(bit typed, logic kind,
		logic [elo_pkg::PLAYER_W-1:0] a, logic [elo_pkg::PLAYER_W-1:0] b,
		logic [elo_pkg::OUTCOME_W-1:0] oc, logic [31:0] lv, logic last,
		logic [elo_pkg::PROB_W-1:0] wp, logic [31:0] ra, logic [31:0] rb);
		dir_row_t row;
		row.item.kind = kind;
		row.item.player_a = a;
		row.item.player_b = b;
		row.item.outcome = oc;
		row.item.load_value = lv;
		row.item.batch_last = last;
		row.typed = typed;
		row.want.win_prob = wp;
		row.want.rating_a_after = ra;
		row.want.rating_b_after = rb;
		row.want.batch_end = last;
		return row;
	endfunction

	function automatic elo_pkg::req_t random_item(logic [elo_pkg::PLAYER_W-1:0] base);
		elo_pkg::req_t r;
		int            sel;
		r.kind = ($urandom_range(99) < 15) ? elo_pkg::KIND_LOAD : elo_pkg::KIND_MATCH;
		if ($urandom_range(9) == 0) begin
			r.player_a = elo_pkg::PLAYER_W'($urandom);
			r.player_b = elo_pkg::PLAYER_W'($urandom);
		end else begin
			r.player_a = base + elo_pkg::PLAYER_W'($urandom_range(15));
			r.player_b = base + elo_pkg::PLAYER_W'($urandom_range(15));
		end
		if ($urandom_range(19) == 0) begin
			r.player_b = r.player_a;
		end
		sel = $urandom_range(9);
		case (sel)
			0: r.outcome = '0;
			1: r.outcome = elo_pkg::OUTCOME_W'(65536);
			2: r.outcome = elo_pkg::OUTCOME_W'(32768);
			3: r.outcome = elo_pkg::OUTCOME_W'($urandom_range(131071, 65537));
			default: r.outcome = elo_pkg::OUTCOME_W'($urandom_range(65536));
		endcase
		sel = $urandom_range(9);
		case (sel)
			0: r.load_value = 32'h7fff_ffff;
			1: r.load_value = 32'h8000_0000;
			2, 3: r.load_value = $urandom;
			default: r.load_value = int'($urandom_range(1 << 26)) - (1 << 25);
		endcase
		r.batch_last = 1'($urandom_range(1));
		return r;
	endfunction

	task automatic write_reg(logic [elo_pkg::CFG_IDX_W-1:0] idx,
		logic [elo_pkg::CFG_W-1:0] value);
		cfg.valid <= 1'b1;
		cfg.idx <= idx;
		cfg.data <= value;
		do @(posedge clk); while (!cfg.ready);
		case (idx)
			elo_pkg::REG_K_FACTOR: k_gain = value;
			elo_pkg::REG_ALPHA: logit_gain = value;
			default: ;
		endcase
	endtask

	task automatic send(elo_pkg::req_t item, bit typed, elo_pkg::res_t want);
		elo_pkg::res_t guess;
		if (!calm && $urandom_range(99) < 38) begin
			req.valid <= 1'b0;
			repeat ($urandom_range(3, 1)) @(posedge clk);
		end
		req.valid <= 1'b1;
		req.kind <= item.kind;
		req.player_a <= item.player_a;
		req.player_b <= item.player_b;
		req.outcome <= item.outcome;
		req.load_value <= item.load_value;
		req.batch_last <= item.batch_last;
		do @(posedge clk); while (!req.ready);
		guess = elo_predict(item);
		pending_results.push_back(typed ? want : guess);
	endtask

	task automatic run_phase(logic [elo_pkg::CFG_W-1:0] k, logic [elo_pkg::CFG_W-1:0] a,
		int count, bit quiet, bit squeeze);
		elo_pkg::req_t                item;
		logic [elo_pkg::PLAYER_W-1:0] base;
		while (pending_results.size() != 0) @(posedge clk);
		write_reg(elo_pkg::REG_K_FACTOR, k);
		write_reg(elo_pkg::REG_ALPHA, a);
		cfg.valid <= 1'b0;
		calm = quiet;
		base = elo_pkg::PLAYER_W'($urandom);
		for (int i = 0; i < count; i++) begin
			if (squeeze && i == count / 3) begin
				hold_off = 1'b1;
			end
			if ($urandom_range(99) < 3) begin
				base = elo_pkg::PLAYER_W'($urandom);
			end
			item = random_item(base);
			send(item, 1'b0, '0);
		end
		req.valid <= 1'b0;
		calm = 1'b0;
	endtask

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	// result side: random stalls, plus one long hold-off on request
	initial begin : rsp_side
		bit held;
		held = 1'b0;
		rsp.ready <= 1'b0;
		forever begin
			@(posedge clk);
			if (hold_off && !held) begin
				held = 1'b1;
				rsp.ready <= 1'b0;
				repeat (HOLD_CYCLES) @(posedge clk);
			end
			rsp.ready <= calm || ($urandom_range(99) >= 38);
		end
	end

	always @(posedge clk) begin : result_check
		elo_pkg::res_t want;
		if (arst_n && rsp.valid && rsp.ready) begin
			if (pending_results.size() == 0) begin
				$display("%0t: unexpected result expected none got %0h/%0h/%0h/%0h", $time,
					rsp.win_prob, rsp.rating_a_after, rsp.rating_b_after, rsp.batch_end);
				errors++;
			end else begin
				want = pending_results.pop_front();
				check_field("win_prob", 32'(want.win_prob), 32'(rsp.win_prob));
				check_field("rating_a_after", want.rating_a_after, rsp.rating_a_after);
				check_field("rating_b_after", want.rating_b_after, rsp.rating_b_after);
				check_field("batch_end", 32'(want.batch_end), 32'(rsp.batch_end));
			end
		end
	end

	always @(posedge clk) begin
		if ((req.valid && req.ready) || (rsp.valid && rsp.ready) || (cfg.valid && cfg.ready)) begin
			idle_cycles <= 0;
		end else if (idle_cycles == IDLE_LIMIT) begin
			$display("elo_rating_update verification failed");
			$finish;
		end else begin
			idle_cycles <= idle_cycles + 1;
		end
	end

	initial begin : stimulus
		dir_row_t rows [$];
		build_lut();
		foreach (rating_mem[i]) rating_mem[i] = 0;
		k_gain = elo_pkg::K_FACTOR_RST;
		logit_gain = elo_pkg::ALPHA_RST;
		arst_n <= 1'b0;
		req.valid <= 1'b0;
		req.kind <= elo_pkg::KIND_MATCH;
		req.player_a <= '0;
		req.player_b <= '0;
		req.outcome <= '0;
		req.load_value <= '0;
		req.batch_last <= 1'b0;
		cfg.valid <= 1'b0;
		cfg.idx <= elo_pkg::REG_K_FACTOR;
		cfg.data <= '0;
		repeat (9) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		write_reg(elo_pkg::REG_K_FACTOR, elo_pkg::K_FACTOR_RST);
		write_reg(elo_pkg::REG_ALPHA, elo_pkg::ALPHA_RST);
		cfg.valid <= 1'b0;

		// even ratings, win / loss / draw / over-range outcome
		rows.push_back(mk_row(1, elo_pkg::KIND_MATCH, 0, 1, 65536, 0, 0, 32768,
			32'h0010_0000, 32'hfff0_0000));
		rows.push_back(mk_row(1, elo_pkg::KIND_MATCH, 2, 3, 0, 0, 1, 32768,
			32'hfff0_0000, 32'h0010_0000));
		rows.push_back(mk_row(1, elo_pkg::KIND_MATCH, 4, 5, 32768, 0, 0, 32768, 0, 0));
		rows.push_back(mk_row(1, elo_pkg::KIND_MATCH, 6, 7, 131071, 0, 0, 32768,
			32'h002f_ffe0, 32'hffd0_0020));
		// same player
		rows.push_back(mk_row(1, elo_pkg::KIND_MATCH, 1023, 1023, 65536, 0, 1, 32768, 0, 0));
		// rating extremes, logit clamp both ways, saturation
		rows.push_back(mk_row(1, elo_pkg::KIND_LOAD, 1023, 5, 131071, 32'h7fff_ffff, 1, 0,
			32'h7fff_ffff, 0));
		rows.push_back(mk_row(1, elo_pkg::KIND_LOAD, 1022, 1023, 0, 32'h8000_0000, 0, 0,
			32'h8000_0000, 0));
		rows.push_back(mk_row(0, elo_pkg::KIND_MATCH, 1023, 1022, 65536, 0, 0, 0, 0, 0));
		rows.push_back(mk_row(0, elo_pkg::KIND_MATCH, 1022, 1023, 0, 0, 1, 0, 0, 0));
		rows.push_back(mk_row(0, elo_pkg::KIND_MATCH, 1023, 1022, 0, 0, 0, 0, 0, 0));
		rows.push_back(mk_row(0, elo_pkg::KIND_MATCH, 1022, 1023, 131071, 0, 1, 0, 0, 0));
		rows.push_back(mk_row(1, elo_pkg::KIND_LOAD, 8, 0, 0, 32'hffff_ffff, 0, 0,
			32'hffff_ffff, 0));
		rows.push_back(mk_row(0, elo_pkg::KIND_MATCH, 8, 9, 65536, 0, 0, 0, 0, 0));
		rows.push_back(mk_row(1, elo_pkg::KIND_LOAD, 12, 0, 0, 12345678, 0, 0, 12345678, 0));
		rows.push_back(mk_row(1, elo_pkg::KIND_MATCH, 12, 12, 0, 0, 1, 32768,
			12345678, 12345678));
		// back-to-back on the same players
		rows.push_back(mk_row(0, elo_pkg::KIND_MATCH, 0, 1, 65536, 0, 0, 0, 0, 0));
		rows.push_back(mk_row(0, elo_pkg::KIND_MATCH, 0, 1, 65536, 0, 0, 0, 0, 0));
		rows.push_back(mk_row(0, elo_pkg::KIND_MATCH, 1, 0, 32768, 0, 1, 0, 0, 0));
		rows.push_back(mk_row(0, elo_pkg::KIND_MATCH, 2, 0, 65536, 0, 0, 0, 0, 0));
		rows.push_back(mk_row(0, elo_pkg::KIND_MATCH, 1023, 0, 65536, 0, 1, 0, 0, 0));
		foreach (rows[i]) send(rows[i].item, rows[i].typed, rows[i].want);
		req.valid <= 1'b0;

		run_phase(elo_pkg::K_FACTOR_RST, elo_pkg::ALPHA_RST, PHASE_ITEMS, 1'b0, 1'b0);
		run_phase(32'hffff_ffff, 32'hffff_ffff, PHASE_ITEMS, 1'b0, 1'b0);
		while (pending_results.size() != 0) @(posedge clk);
		write_reg(REG_SPARE_2, $urandom);
		write_reg(REG_SPARE_3, $urandom);
		run_phase(32'd0, 32'd0, PHASE_ITEMS, 1'b0, 1'b0);
		run_phase(32'd65536, $urandom_range(1 << 22), PHASE_ITEMS, 1'b1, 1'b0);
		run_phase($urandom, $urandom_range(1 << 20), PHASE_ITEMS, 1'b0, 1'b1);
		run_phase(elo_pkg::K_FACTOR_RST, elo_pkg::ALPHA_RST, PHASE_ITEMS, 1'b0, 1'b0);

		while (pending_results.size() != 0) @(posedge clk);
		repeat (20) @(posedge clk);
		if (errors == 0) begin
			$display("elo_rating_update verification clean");
		end else begin
			$display("elo_rating_update verification failed");
		end
		$finish;
	end

endmodule

`default_nettype wire

@@ elo_rating_update.f @@
+incdir+design
design/elo_pkg.sv
design/elo_if.sv
design/elo_prob_rom.sv
design/elo_ctrl.sv
design/elo_dp.sv
design/elo_rating_update.sv
tb/tb.sv
